@@ hw/rtl/gae_pkg.sv @@
// shared types, constants and register indexes for the advantage and loss block
package gae_pkg;

	localparam int MAX_STEPS_DEF = 256;
	localparam int MAX_ENVS_DEF  = 8;

	localparam int CFG_IW  = 3;
	localparam int CFG_DW  = 16;
	localparam int STEPS_W = 9;
	localparam int ENVS_W  = 4;
	// width of the element count steps times envs
	localparam int NW      = STEPS_W + ENVS_W;

	localparam logic [CFG_IW-1:0] REG_DISCOUNT = 3'd0;
	localparam logic [CFG_IW-1:0] REG_LAMBDA   = 3'd1;
	localparam logic [CFG_IW-1:0] REG_ENT_COEF = 3'd2;
	localparam logic [CFG_IW-1:0] REG_STEPS    = 3'd3;
	localparam logic [CFG_IW-1:0] REG_ENVS     = 3'd4;

	typedef struct packed {
		logic signed [31:0] reward;
		logic signed [31:0] state_value;
		logic               continue_mask;
		logic signed [31:0] log_prob;
		logic        [30:0] entropy;
		logic               last_element;
	} in_item_t;

	typedef struct packed {
		logic        [30:0] value_cost;
		logic signed [31:0] policy_cost;
		logic               status;
	} out_item_t;

	// one stored rollout element
	typedef struct packed {
		logic signed [31:0] reward;
		logic signed [31:0] state_value;
		logic               continue_mask;
		logic signed [31:0] log_prob;
	} entry_t;

	typedef struct packed {
		logic          start;
		logic [63:0]   dividend;
		logic [NW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
	} div_rsp_t;

endpackage

@@ hw/rtl/gae_store.sv @@
// rollout element memory, one write port and one registered read port
module gae_store #(
	parameter int DEPTH = gae_pkg::MAX_STEPS_DEF * gae_pkg::MAX_ENVS_DEF,
	parameter int AW    = $clog2(gae_pkg::MAX_STEPS_DEF * gae_pkg::MAX_ENVS_DEF)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  gae_pkg::entry_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output gae_pkg::entry_t rdata
);
	import gae_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	// write, and read through a registered output
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/gae_div.sv @@
// restoring divider, one quotient bit per cycle, 64-bit dividend
module gae_div (
	input  logic              clk,
	input  logic              arst_n,
	input  gae_pkg::div_req_t req,
	output gae_pkg::div_rsp_t rsp
);
	import gae_pkg::*;

	logic          busy_q;
	logic          done_q;
	logic [5:0]    cnt_q;
	logic [NW:0]   rem_q;
	logic [63:0]   quo_q;
	logic [NW-1:0] dvs_q;

	logic [NW:0]   rem_sh;
	logic          ge;
	logic [NW:0]   rem_nx;

	// shift in the next dividend bit and try a subtract
	always_comb begin
		rem_sh = {rem_q[NW-1:0], quo_q[63]};
		ge     = rem_sh >= {1'b0, dvs_q};
		rem_nx = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[62:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

@@ hw/rtl/gae_advantage_loss.sv @@
// top level: rollout loading, backward advantage scan and loss output
//
// Usage: rollout elements come in on the input channel, time-major then
// environment order, one per cycle while the block is loading. The element
// flagged last_element closes the rollout; the block then stalls the input,
// scans each environment backward through the element memory and emits one
// result transfer with the critic loss, the actor loss and a status bit.
// Rate: loading accepts one element per cycle. The scan is set by the
// read-modify sequencer over the element memory's read port: a check
// state, a fetch of each environment's final value, then per remaining
// element the read, multiply, add, square and accumulate states. Three
// divisions by N follow on the shared divider, then the result is formed
// and registered. A bad configuration or element count skips the scan and
// the divisions, going from the check state straight to the output state,
// and gives status 1 with zero losses. Reset sets the configuration
// registers to their defaults and clears the element count and sums;
// memory contents are left as they are. The result sits in an output
// register: while the receiver stalls, the next rollout may load, and its
// result waits until the earlier one is transferred.
module gae_advantage_loss #(
	parameter int MAX_STEPS = gae_pkg::MAX_STEPS_DEF,
	parameter int MAX_ENVS  = gae_pkg::MAX_ENVS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [gae_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [gae_pkg::CFG_DW-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  gae_pkg::in_item_t            in_item,
	output logic                         out_valid,
	input  logic                         out_stall,
	output gae_pkg::out_item_t           out_item
);
	import gae_pkg::*;

	localparam int DEPTH = MAX_STEPS * MAX_ENVS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 2);
	localparam int ESW   = 31 + AW;
	localparam int XW    = ESW + 20;

	localparam logic signed [64:0]   WS_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [64:0]   WS_MIN = -WS_MAX;
	localparam logic signed [34:0]   S35_MAX = 35'sd2147483647;
	localparam logic signed [34:0]   S35_MIN = -35'sd2147483648;
	localparam logic signed [XW-1:0] A_MAX = XW'(64'sd2147483647);
	localparam logic signed [XW-1:0] A_MIN = -A_MAX - XW'(1);

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_CHK   = 13'b0000000000010,
		S_FRD   = 13'b0000000000100,
		S_FWAIT = 13'b0000000001000,
		S_RD    = 13'b0000000010000,
		S_MUL1  = 13'b0000000100000,
		S_ADD   = 13'b0000001000000,
		S_MUL2  = 13'b0000010000000,
		S_ACC   = 13'b0000100000000,
		S_DGO   = 13'b0001000000000,
		S_DWAIT = 13'b0010000000000,
		S_FIN   = 13'b0100000000000,
		S_OUT   = 13'b1000000000000
	} state_t;

	// configuration registers
	logic [15:0]        disc_q, lam_q, coef_q;
	logic [STEPS_W-1:0] steps_q;
	logic [ENVS_W-1:0]  envs_q;

	// control state
	state_t             state_q;
	logic               err_q;
	logic [CW-1:0]      count_q;
	logic [ESW-1:0]     esum_q;
	logic [63:0]        sq_q;
	logic signed [63:0] ws_q;
	logic [AW-1:0]      addr_q;
	logic [ENVS_W-1:0]  env_q;
	logic [STEPS_W-1:0] left_q;
	logic [1:0]         div_sel_q;
	logic               out_valid_q;

	// datapath registers
	logic [15:0]         gl_q;
	logic [AW-1:0]       base_q;
	logic signed [31:0]  vnext_q, r_q, v_q, lp_q, a_q;
	logic                m_q;
	logic signed [48:0]  pg_q, pa_q;
	logic [63:0]         sqp_q;
	logic signed [63:0]  pp_q;
	logic [63:0]         qsq_q, qws_q, qen_q;
	logic [30:0]         crit_q;
	logic signed [48:0]  pol_q;
	logic [ESW+15:0]     entp_q;
	out_item_t           out_q;

	logic               in_acc, out_free, mem_we, mem_re, cfg_bad;
	logic [NW-1:0]      n_w, base_w;
	entry_t             wentry, rentry;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	logic signed [34:0] d_raw, a_raw;
	logic signed [31:0] d_sat, a_nx;
	logic signed [63:0] sq_prod, lp_prod;
	logic [64:0]        sq_sum;
	logic signed [64:0] ws_sum;
	logic [63:0]        ws_mag;
	logic [48:0]        crit_r;
	logic signed [63:0] m_w;
	logic [ESW-1:0]     ent_r;
	logic signed [XW-1:0] actor_raw;
	logic signed [31:0] actor_sat;

	// handshakes
	assign in_acc   = in_valid && !in_stall;
	assign in_stall = state_q != S_IDLE;
	assign out_free = !out_valid_q || !out_stall;

	// element store
	assign mem_we = in_acc && (count_q < CW'(DEPTH));
	assign mem_re = (state_q == S_FRD) || (state_q == S_RD);
	always_comb begin
		wentry.reward        = in_item.reward;
		wentry.state_value   = in_item.state_value;
		wentry.continue_mask = in_item.continue_mask;
		wentry.log_prob      = in_item.log_prob;
	end

	gae_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (count_q[AW-1:0]),
		.wdata (wentry),
		.re    (mem_re),
		.raddr (addr_q),
		.rdata (rentry)
	);

	// shared divider by the element count
	always_comb begin
		ws_mag = ws_q[63] ? 64'(-ws_q) : 64'(ws_q);
		div_req.start   = state_q == S_DGO;
		div_req.divisor = n_w;
		unique case (div_sel_q)
			2'd0:    div_req.dividend = sq_q;
			2'd1:    div_req.dividend = ws_mag;
			default: div_req.dividend = 64'(esum_q);
		endcase
	end

	gae_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// rollout checks
	always_comb begin
		n_w     = NW'(steps_q) * NW'(envs_q);
		base_w  = NW'(steps_q - STEPS_W'(1)) * NW'(envs_q);
		cfg_bad = (steps_q == '0) || (32'(steps_q) > MAX_STEPS) ||
			(envs_q == '0) || (32'(envs_q) > MAX_ENVS) ||
			(32'(count_q) != 32'(n_w));
	end

	// td residual and advantage recurrence
	always_comb begin
		d_raw = 35'(r_q) - 35'(v_q) +
			(m_q ? 35'(pg_q >>> 16) + 35'({1'b0, pg_q[15]}) : 35'sd0);
		if (d_raw > S35_MAX) begin
			d_sat = 32'sh7FFF_FFFF;
		end else if (d_raw < S35_MIN) begin
			d_sat = 32'sh8000_0000;
		end else begin
			d_sat = d_raw[31:0];
		end
		a_raw = (m_q ? 35'(pa_q >>> 16) + 35'({1'b0, pa_q[15]}) : 35'sd0) + 35'(d_sat);
		if (a_raw > S35_MAX) begin
			a_nx = 32'sh7FFF_FFFF;
		end else if (a_raw < S35_MIN) begin
			a_nx = 32'sh8000_0000;
		end else begin
			a_nx = a_raw[31:0];
		end
	end

	// squared and weighted terms, saturating sums
	assign sq_prod = a_q * a_q;
	assign lp_prod = lp_q * a_q;
	assign sq_sum  = {1'b0, sq_q} + {1'b0, sqp_q};
	assign ws_sum  = 65'(ws_q) + 65'(pp_q);

	// loss formation
	always_comb begin
		crit_r = 49'(qsq_q >> 16) + 49'(qsq_q[15]);
		m_w    = ws_q[63] ? -$signed(qws_q) : $signed(qws_q);
		ent_r  = ESW'(entp_q >> 16) + ESW'(entp_q[15]);
		actor_raw = -XW'(pol_q) - XW'(ent_r);
		if (actor_raw > A_MAX) begin
			actor_sat = 32'sh7FFF_FFFF;
		end else if (actor_raw < A_MIN) begin
			actor_sat = 32'sh8000_0000;
		end else begin
			actor_sat = actor_raw[31:0];
		end
	end

	// configuration, sequencer and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disc_q      <= 16'd64880;
			lam_q       <= 16'd62259;
			coef_q      <= 16'd655;
			steps_q     <= STEPS_W'(256);
			envs_q      <= ENVS_W'(8);
			state_q     <= S_IDLE;
			err_q       <= 1'b0;
			count_q     <= '0;
			esum_q      <= '0;
			sq_q        <= '0;
			ws_q        <= '0;
			addr_q      <= '0;
			env_q       <= '0;
			left_q      <= '0;
			div_sel_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DISCOUNT: disc_q  <= cfg_data[15:0];
					REG_LAMBDA:   lam_q   <= cfg_data[15:0];
					REG_ENT_COEF: coef_q  <= cfg_data[15:0];
					REG_STEPS:    steps_q <= cfg_data[STEPS_W-1:0];
					REG_ENVS:     envs_q  <= cfg_data[ENVS_W-1:0];
					default: ;
				endcase
			end

			// result register: loaded from the output state, emptied by a transfer
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (count_q < CW'(DEPTH)) begin
							esum_q <= esum_q + ESW'(in_item.entropy);
						end
						if (count_q < CW'(DEPTH + 1)) begin
							count_q <= count_q + CW'(1);
						end
						if (in_item.last_element) begin
							state_q <= S_CHK;
						end
					end
				end
				S_CHK: begin
					err_q     <= cfg_bad;
					div_sel_q <= '0;
					env_q     <= '0;
					addr_q    <= AW'(base_w);
					if (cfg_bad) begin
						state_q <= S_OUT;
					end else if (steps_q == STEPS_W'(1)) begin
						state_q <= S_DGO;
					end else begin
						state_q <= S_FRD;
					end
				end
				S_FRD: state_q <= S_FWAIT;
				S_FWAIT: begin
					left_q  <= steps_q - STEPS_W'(1);
					addr_q  <= addr_q - AW'(envs_q);
					state_q <= S_RD;
				end
				S_RD:   state_q <= S_MUL1;
				S_MUL1: state_q <= S_ADD;
				S_ADD:  state_q <= S_MUL2;
				S_MUL2: state_q <= S_ACC;
				S_ACC: begin
					sq_q <= sq_sum[64] ? '1 : sq_sum[63:0];
					if (ws_sum > WS_MAX) begin
						ws_q <= WS_MAX[63:0];
					end else if (ws_sum < WS_MIN) begin
						ws_q <= WS_MIN[63:0];
					end else begin
						ws_q <= ws_sum[63:0];
					end
					left_q <= left_q - STEPS_W'(1);
					if (left_q == STEPS_W'(1)) begin
						if (env_q + ENVS_W'(1) == envs_q) begin
							state_q <= S_DGO;
						end else begin
							env_q   <= env_q + ENVS_W'(1);
							addr_q  <= base_q + AW'(env_q) + AW'(1);
							state_q <= S_FRD;
						end
					end else begin
						addr_q  <= addr_q - AW'(envs_q);
						state_q <= S_RD;
					end
				end
				S_DGO: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (div_rsp.done) begin
						if (div_sel_q == 2'd2) begin
							state_q <= S_FIN;
						end else begin
							div_sel_q <= div_sel_q + 2'd1;
							state_q   <= S_DGO;
						end
					end
				end
				S_FIN: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						count_q     <= '0;
						esum_q      <= '0;
						sq_q        <= '0;
						ws_q        <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_CHK: begin
				gl_q   <= 16'(({16'd0, disc_q} * {16'd0, lam_q} + 32'h8000) >> 16);
				base_q <= AW'(base_w);
			end
			S_FWAIT: begin
				vnext_q <= rentry.state_value;
				a_q     <= '0;
			end
			S_MUL1: begin
				r_q     <= rentry.reward;
				v_q     <= rentry.state_value;
				m_q     <= rentry.continue_mask;
				lp_q    <= rentry.log_prob;
				pg_q    <= $signed({1'b0, disc_q}) * vnext_q;
				pa_q    <= $signed({1'b0, gl_q}) * a_q;
				vnext_q <= rentry.state_value;
			end
			S_ADD: a_q <= a_nx;
			S_MUL2: begin
				sqp_q <= 64'(sq_prod);
				pp_q  <= lp_prod;
			end
			S_DWAIT: begin
				if (div_rsp.done) begin
					unique case (div_sel_q)
						2'd0:    qsq_q <= div_rsp.quotient;
						2'd1:    qws_q <= div_rsp.quotient;
						default: qen_q <= div_rsp.quotient;
					endcase
				end
			end
			S_FIN: begin
				crit_q <= (crit_r > 49'h7FFF_FFFF) ? 31'h7FFF_FFFF : crit_r[30:0];
				pol_q  <= 49'(m_w >>> 16) + 49'({1'b0, m_w[15]});
				entp_q <= coef_q * qen_q[ESW-1:0];
			end
			S_OUT: begin
				if (out_free) begin
					out_q.status      <= err_q;
					out_q.value_cost  <= err_q ? '0 : crit_q;
					out_q.policy_cost <= err_q ? '0 : actor_sat;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// element count never runs past its saturation point
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= DEPTH + 1)
		else $error("element count beyond saturation");

	// a rejected rollout is never scanned
	a_no_scan_on_err: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> !err_q)
		else $error("scan running on a rejected rollout");

	// divider results only arrive while the sequencer waits for them
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DWAIT))
		else $error("divider finished outside its wait state");

	// a result transfer is loaded only from the output state
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result loaded outside the output state");

endmodule
